/* sv/cpc_pkg.sv */
// Shared types, constants and angle table of the rectangular/polar converter.
package cpc_pkg;

  localparam int ITERATIONS = 16;
  localparam int TABLE_LEN  = 24;
  localparam int NUM_ITER   = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;

  localparam int DW        = 36;
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 16;
  localparam int MAG_W     = 17;

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [31:0] ANGLE_STEP [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic {
    MODE_TO_POLAR = 1'b0,
    MODE_TO_CART  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                 mode;
    logic                  zero;
    logic signed [DW-1:0]  x;
    logic signed [DW-1:0]  y;
    logic        [31:0]    z;
  } cpc_item_t;

endpackage

/* sv/cpc_pre.sv */
// Input stage: quadrant folding, Q.16 scaling and gain compensation.
module cpc_pre (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   mode_i,
  input  logic signed [15:0]     in_first_i,
  input  logic signed [15:0]     in_second_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cpc_pkg::cpc_item_t     out_item_o
);
  import cpc_pkg::*;

  logic signed [IN_W:0]   a_ext, b_ext, a_neg, b_neg, r_val;
  logic        [31:0]     z_in;
  logic                   flip;
  logic signed [47:0]     prod;
  logic signed [47:0]     prod_rnd;
  cpc_item_t              item_d, item_q;
  logic                   valid_q;

  assign a_ext = {in_first_i[IN_W-1], in_first_i};
  assign b_ext = {in_second_i[IN_W-1], in_second_i};
  assign a_neg = -a_ext;
  assign b_neg = -b_ext;

  assign z_in  = {in_second_i, 16'b0};
  assign flip  = z_in[31] ^ z_in[30];
  assign r_val = flip ? a_neg : a_ext;
  assign prod  = r_val * $signed({1'b0, GAIN_Q30});
  assign prod_rnd = (prod + 48'sd8192) >>> 14;

  always_comb begin
    item_d      = '0;
    item_d.mode = mode_e'(mode_i);
    if (mode_i == MODE_TO_POLAR) begin
      item_d.zero = (in_first_i == '0) && (in_second_i == '0);
      if (in_first_i[IN_W-1]) begin
        item_d.x = {{(DW-IN_W-1-FRAC_BITS){a_neg[IN_W]}}, a_neg, {FRAC_BITS{1'b0}}};
        item_d.y = {{(DW-IN_W-1-FRAC_BITS){b_neg[IN_W]}}, b_neg, {FRAC_BITS{1'b0}}};
        item_d.z = 32'h8000_0000;
      end else begin
        item_d.x = {{(DW-IN_W-1-FRAC_BITS){a_ext[IN_W]}}, a_ext, {FRAC_BITS{1'b0}}};
        item_d.y = {{(DW-IN_W-1-FRAC_BITS){b_ext[IN_W]}}, b_ext, {FRAC_BITS{1'b0}}};
        item_d.z = '0;
      end
    end else begin
      item_d.zero = 1'b0;
      item_d.x    = prod_rnd[DW-1:0];
      item_d.y    = '0;
      item_d.z    = {z_in[31] ^ flip, z_in[30:0]};
    end
  end

  assign in_ready_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

/* sv/cpc_rotator.sv */
// Unrolled CORDIC micro-rotation pipeline, one register stage per iteration.
module cpc_rotator (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cpc_pkg::cpc_item_t     in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output cpc_pkg::cpc_item_t     out_item_o
);
  import cpc_pkg::*;

  cpc_item_t stg      [NUM_ITER+1];
  logic      stg_vld  [NUM_ITER+1];
  logic      stg_rdy  [NUM_ITER+1];

  assign stg[0]             = in_item_i;
  assign stg_vld[0]         = in_valid_i;
  assign stg_rdy[NUM_ITER]  = out_ready_i;

  for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
    logic signed [DW-1:0] xs, ys, dx, dy;
    logic                 dir;
    cpc_item_t            item_d, item_q;
    logic                 valid_q;

    assign xs  = stg[k].x;
    assign ys  = stg[k].y;
    assign dx  = ys >>> k;
    assign dy  = xs >>> k;
    assign dir = (stg[k].mode == MODE_TO_CART) ? stg[k].z[31] : ~ys[DW-1];

    always_comb begin
      item_d = stg[k];
      if (dir) begin
        item_d.x = xs + dx;
        item_d.y = ys - dy;
        item_d.z = stg[k].z + ANGLE_STEP[k];
      end else begin
        item_d.x = xs - dx;
        item_d.y = ys + dy;
        item_d.z = stg[k].z - ANGLE_STEP[k];
      end
    end

    assign stg_rdy[k] = ~valid_q | stg_rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (stg_rdy[k]) begin
        valid_q <= stg_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[k] && stg_vld[k]) begin
        item_q <= item_d;
      end
    end

    assign stg[k+1]     = item_q;
    assign stg_vld[k+1] = valid_q;
  end

  assign in_ready_o  = stg_rdy[0];
  assign out_valid_o = stg_vld[NUM_ITER];
  assign out_item_o  = stg[NUM_ITER];

endmodule

/* sv/cpc_post.sv */
// Output stages: gain scaling of the magnitude, rounding and saturation.
module cpc_post (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  cpc_pkg::cpc_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [16:0]       out_first_o,
  output logic signed [15:0]       out_second_o
);
  import cpc_pkg::*;

  localparam int RW = DW - FRAC_BITS;

  typedef struct packed {
    mode_e                 mode;
    logic                  zero;
    logic        [47:0]    pp_lo;
    logic signed [47:0]    pp_hi;
    logic signed [RW-1:0]  rx;
    logic signed [RW-1:0]  ry;
    logic        [15:0]    ang;
  } cpc_part_t;

  function automatic logic signed [15:0] sat16(input logic signed [RW-1:0] v);
    logic signed [15:0] res;
    if (v > RW'(32767)) begin
      res = 16'sh7FFF;
    end else if (v < -RW'(32768)) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  logic signed [DW-1:0]  cx, cy;
  logic signed [DW-1:0]  cx_rnd, cy_rnd;
  logic        [31:0]    z_rnd;
  cpc_part_t             part_d, part_q;
  logic                  v1_q, v2_q, rdy1;
  logic signed [67:0]    mag_sum;
  logic signed [15:0]    sx, sy;
  logic signed [16:0]    first_d, first_q;
  logic signed [15:0]    second_d, second_q;

  assign cx     = in_item_i.x;
  assign cy     = in_item_i.y;
  assign cx_rnd = (cx + DW'(32768)) >>> FRAC_BITS;
  assign cy_rnd = (cy + DW'(32768)) >>> FRAC_BITS;
  assign z_rnd  = in_item_i.z + 32'h0000_8000;

  always_comb begin
    part_d.mode  = in_item_i.mode;
    part_d.zero  = in_item_i.zero;
    part_d.pp_lo = cx[17:0] * GAIN_Q30;
    part_d.pp_hi = $signed(cx[DW-1:18]) * $signed({1'b0, GAIN_Q30});
    part_d.rx    = cx_rnd[RW-1:0];
    part_d.ry    = cy_rnd[RW-1:0];
    part_d.ang   = z_rnd[31:16];
  end

  assign mag_sum = {{2{part_q.pp_hi[47]}}, part_q.pp_hi, 18'b0}
                 + {20'b0, part_q.pp_lo} + (68'sd1 <<< 45);
  assign sx = sat16(part_q.rx);
  assign sy = sat16(part_q.ry);

  always_comb begin
    if (part_q.mode == MODE_TO_CART) begin
      first_d  = {sx[15], sx};
      second_d = sy;
    end else if (part_q.zero) begin
      first_d  = '0;
      second_d = '0;
    end else begin
      first_d  = mag_sum[62:46];
      second_d = part_q.ang;
    end
  end

  assign rdy1       = ~v2_q | out_ready_i;
  assign in_ready_o = ~v1_q | rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        v1_q <= in_valid_i;
      end
      if (rdy1) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      part_q <= part_d;
    end
    if (rdy1 && v1_q) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign out_valid_o  = v2_q;
  assign out_first_o  = first_q;
  assign out_second_o = second_q;

endmodule

/* sv/cartesian_polar_converter_top.sv */
// Top level of the pipelined CORDIC rectangular/polar converter.
// The converter takes one transfer per clock unless a full pipeline is stalled at the output.
// Its stages are one input stage, one register stage per CORDIC micro-rotation, and two
// output stages for the gain multiply and rounding.
// Every stage holds its own valid bit, so a stalled output only stops the stages behind
// it that are full, and empty stages keep filling while a result waits.
module cartesian_polar_converter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic signed [15:0]  in_first_i,
  input  logic signed [15:0]  in_second_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  out_first_o,
  output logic signed [15:0]  out_second_o
);
  import cpc_pkg::*;

  cpc_item_t pre_item, rot_item;
  logic      pre_valid, pre_ready, rot_valid, rot_ready;

  cpc_pre u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .in_first_i  (in_first_i),
    .in_second_i (in_second_i),
    .out_valid_o (pre_valid),
    .out_ready_i (pre_ready),
    .out_item_o  (pre_item)
  );

  cpc_rotator u_rotator (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_valid),
    .in_ready_o  (pre_ready),
    .in_item_i   (pre_item),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_item_o  (rot_item)
  );

  cpc_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (rot_valid),
    .in_ready_o   (rot_ready),
    .in_item_i    (rot_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_first_o  (out_first_o),
    .out_second_o (out_second_o)
  );

  // A ready output side must let the whole pipeline advance.
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_o)
    else $error("Input stalled while the output side is ready.");

  // The input can only be blocked when the pipeline is full up to the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_ready_o |-> out_valid_o)
    else $error("Input stalled with no result waiting at the output.");

  // The rotator can only be blocked while the output holds a result that is not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_valid && !rot_ready) |-> (out_valid_o && !out_ready_i))
    else $error("Rotator blocked without an output stall.");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the pipelined CORDIC rectangular/polar converter.
`timescale 1ns / 100ps

module tb_top;
  import cpc_pkg::*;

  localparam int     ROTATIONS       = NUM_ITER;
  localparam longint CORDIC_GAIN_Q30 = 652032874;
  localparam int     DRAIN_CYCLES    = 40;

  typedef struct {
    mode_e              mode;
    logic signed [15:0] first;
    logic signed [15:0] second;
    int                 send_idle;
    int                 recv_stall;
  } point_t;

  typedef struct packed {
    logic signed [16:0] first;
    logic signed [15:0] second;
  } conv_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mode_e              in_mode = MODE_TO_POLAR;
  logic signed [15:0] in_first = '0;
  logic signed [15:0] in_second = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [16:0] out_first;
  logic signed [15:0] out_second;

  point_t       pending_points[$];
  conv_result_t pending_results[$];
  point_t       next_point;
  conv_result_t oldest;
  logic         in_accepted = 1'b0;
  int           stall_pct = 0;
  int           mismatch_count = 0;

  cartesian_polar_converter_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .mode_i      (in_mode),
    .in_first_i  (in_first),
    .in_second_i (in_second),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_first_o (out_first),
    .out_second_o(out_second)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] atan_step(input int i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      default: return 32'h00000051;
    endcase
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic conv_result_t cordic_convert(input mode_e mode,
                                                  input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
    longint       x, y, cx, cy, dx, dy, v;
    logic [31:0]  z;
    conv_result_t res;
    res = '0;
    x = a;
    y = b;
    if (mode == MODE_TO_POLAR) begin
      if (x == 0 && y == 0) return res;
      z = 32'h0;
      // The left half plane is folded over and starts from pi.
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h80000000;
      end
      cx = x <<< 16;
      cy = y <<< 16;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + atan_step(i);
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - atan_step(i);
        end
      end
      v = (cx * CORDIC_GAIN_Q30 + (longint'(1) <<< 45)) >>> 46;
      res.first = v[16:0];
      z = z + 32'h8000;
      res.second = z[31:16];
    end else begin
      z = {b, 16'h0};
      // Angles in the outer quadrants are turned by pi with the magnitude negated.
      if (z[31] != z[30]) begin
        x = -x;
        z = z + 32'h80000000;
      end
      cx = (x * CORDIC_GAIN_Q30 + (longint'(1) <<< 13)) >>> 14;
      cy = 0;
      for (int i = 0; i < ROTATIONS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (!z[31]) begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - atan_step(i);
        end else begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + atan_step(i);
        end
      end
      v = clamp16((cx + 32768) >>> 16);
      res.first = v[16:0];
      v = clamp16((cy + 32768) >>> 16);
      res.second = v[15:0];
    end
    return res;
  endfunction

  task automatic queue_point(input mode_e mode, input int a, input int b,
                             input int send_idle, input int recv_stall);
    point_t p;
    p.mode = mode;
    p.first = a[15:0];
    p.second = b[15:0];
    p.send_idle = send_idle;
    p.recv_stall = recv_stall;
    pending_points.push_back(p);
  endtask

  function automatic int pick_value(input int kind);
    int corners[6];
    corners = '{-32768, -32767, -1, 0, 1, 32767};
    case (kind)
      0: return $urandom_range(65535, 0) - 32768;
      1: return $urandom_range(32, 0) - 16;
      default: return corners[$urandom_range(5, 0)];
    endcase
  endfunction

  // Driver: presents the next pending point once the previous one has been transferred.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_accepted)) begin
      if (pending_points.size() > 0 &&
          $urandom_range(99, 0) >= pending_points[0].send_idle) begin
        next_point = pending_points.pop_front();
        in_valid  <= 1'b1;
        in_mode   <= next_point.mode;
        in_first  <= next_point.first;
        in_second <= next_point.second;
        stall_pct <= next_point.recv_stall;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  // Monitor: predicts each accepted input and checks each accepted result.
  always @(posedge clk) begin
    in_accepted <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(cordic_convert(in_mode, in_first, in_second));
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: first %0d, second %0d",
                 out_first, out_second);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_first !== oldest.first) begin
            $error("out_first: expected %0d, actual %0d", oldest.first, out_first);
            mismatch_count++;
          end
          if (out_second !== oldest.second) begin
            $error("out_second: expected %0d, actual %0d", oldest.second, out_second);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int    phase;
    int    kind;
    int    idle;
    int    stall;
    int    a;
    int    b;
    mode_e m;

    queue_point(MODE_TO_POLAR, 0, 0, 0, 0);
    queue_point(MODE_TO_POLAR, 32767, 0, 0, 0);
    queue_point(MODE_TO_POLAR, -32768, 0, 0, 0);
    queue_point(MODE_TO_POLAR, 0, 32767, 0, 0);
    queue_point(MODE_TO_POLAR, 0, -32768, 0, 0);
    queue_point(MODE_TO_POLAR, -32768, -32768, 0, 0);
    queue_point(MODE_TO_POLAR, 32767, 32767, 0, 0);
    queue_point(MODE_TO_POLAR, -32768, 32767, 0, 0);
    queue_point(MODE_TO_POLAR, -1, 0, 0, 0);
    queue_point(MODE_TO_POLAR, -1, -1, 0, 0);
    queue_point(MODE_TO_POLAR, 1, -1, 0, 0);
    queue_point(MODE_TO_POLAR, -7, 3, 0, 0);
    queue_point(MODE_TO_CART, 32767, 0, 0, 0);
    queue_point(MODE_TO_CART, 32767, 16384, 0, 0);
    queue_point(MODE_TO_CART, 32767, -16384, 0, 0);
    queue_point(MODE_TO_CART, 32767, -32768, 0, 0);
    queue_point(MODE_TO_CART, -32768, -32768, 0, 0);
    queue_point(MODE_TO_CART, -32768, 0, 0, 0);
    queue_point(MODE_TO_CART, -32768, 16383, 0, 0);
    queue_point(MODE_TO_CART, 0, 12345, 0, 0);
    queue_point(MODE_TO_CART, -32768, 8192, 0, 0);
    queue_point(MODE_TO_CART, 32767, -8192, 0, 0);
    queue_point(MODE_TO_CART, 1, -1, 0, 0);
    queue_point(MODE_TO_CART, 100, 16385, 0, 0);

    for (int i = 0; i < 856; i++) begin
      phase = i / 214;
      idle  = (phase == 1) ? 73 : (phase == 3) ? 23 : 0;
      stall = (phase == 2) ? 73 : (phase == 3) ? 23 : 0;
      m = $urandom_range(1, 0) ? MODE_TO_CART : MODE_TO_POLAR;
      kind = $urandom_range(99, 0);
      if (kind < 45) begin
        a = pick_value(0);
        b = pick_value(0);
      end else if (kind < 65) begin
        a = pick_value(1);
        b = pick_value(1);
      end else if (kind < 80) begin
        a = pick_value(2);
        b = ($urandom_range(1, 0) != 0) ? pick_value(2) : pick_value(0);
      end else begin
        // Angles near the quadrant boundaries, or points near the axes.
        a = pick_value(0);
        b = 16384 * $urandom_range(3, 0) - 32768 + pick_value(1);
        if (m == MODE_TO_POLAR && $urandom_range(1, 0) != 0) begin
          b = a;
          a = pick_value(1);
        end
      end
      queue_point(m, a, b, idle, stall);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
sv/cpc_pkg.sv
sv/cpc_pre.sv
sv/cpc_rotator.sv
sv/cpc_post.sv
sv/cartesian_polar_converter_top.sv
tb/tb_top.sv
